### rtl/heartbeat_supervisor_assert.svh
// Assertion macros of the heartbeat supervisor checker.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef HEARTBEAT_SUPERVISOR_ASSERT_SVH
`define HEARTBEAT_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_IMPL(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("heartbeat supervisor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("heartbeat supervisor assertion failed");

`endif

### rtl/hbs_pkg.sv
// Shared types and constants of the heartbeat supervisor.
// Used by the datapath, the controller, the top level and the checker.
package hbs_pkg;

  localparam int unsigned MaxClientsDef = 16;
  localparam logic [31:0] TimeoutReset  = 32'd1000;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_STATE = 2'd3
  } kind_e;

  localparam logic REPORT_SENT = 1'b0;
  localparam logic REPORT_LOST = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] id;
    logic [31:0] stamp;
  } result_t;

  typedef struct packed {
    logic load_in;
    logic reg_slot;
    logic set_run;
    logic rd_in;
    logic rd_scan;
    logic ack_chk;
    logic emit_to;
    logic emit_send;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic hit_to;
    logic hit_send;
    logic pend_valid;
    logic out_free;
    logic running;
  } sts_t;

endpackage

### rtl/hbs_datapath.sv
// Datapath of the heartbeat supervisor: slot flags, sent id and time table,
// timeout register, id counter, result holding and output registers. Uses hbs_pkg.
module hbs_datapath #(
  parameter int unsigned MaxClients = hbs_pkg::MaxClientsDef,
  localparam int unsigned SlotW = (MaxClients > 1) ? $clog2(MaxClients) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hbs_pkg::cmd_t        cmd_i,
  input  logic [SlotW-1:0]     scan_slot_i,
  input  logic [3:0]           client_index_i,
  input  logic [31:0]          ack_id_i,
  input  logic                 run_flag_i,
  input  logic [31:0]          now_ms_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 out_stall_i,
  output hbs_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  output logic                 report_kind_o,
  output logic [3:0]           target_index_o,
  output logic [31:0]          beat_id_o,
  output logic [31:0]          stamp_ms_o,
  output logic                 last_o
);
  import hbs_pkg::*;

  logic [MaxClients-1:0] valid_q, valid_d, await_q, await_d;
  logic [31:0]           timeout_q, id_ctr_q, now_q, ack_q, rd_id_q, rd_time_q;
  logic                  running_q;
  logic [SlotW-1:0]      idx_q, in_slot;
  logic                  idx_ok_q, in_ok;
  logic [31:0]           id_mem   [MaxClients];
  logic [31:0]           time_mem [MaxClients];
  logic [31:0]           elapsed;
  logic                  hit_to, hit_send, out_free, push;
  result_t               pend_q, out_q, new_res;
  logic                  pend_valid_q, out_valid_q, out_last_q;

  assign in_slot  = SlotW'(client_index_i);
  assign in_ok    = {28'd0, client_index_i} < 32'(MaxClients);
  assign elapsed  = now_q - rd_time_q;
  assign hit_to   = valid_q[scan_slot_i] & await_q[scan_slot_i] & (elapsed > timeout_q);
  assign hit_send = valid_q[scan_slot_i] & ~await_q[scan_slot_i];
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign push     = (cmd_i.emit_to | cmd_i.emit_send) & pend_valid_q;

  always_comb begin
    new_res.idx = 4'(scan_slot_i);
    if (cmd_i.emit_to) begin
      new_res.kind  = REPORT_LOST;
      new_res.id    = rd_id_q;
      new_res.stamp = rd_time_q;
    end else begin
      new_res.kind  = REPORT_SENT;
      new_res.id    = id_ctr_q;
      new_res.stamp = now_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    await_d = await_q;
    if (cmd_i.reg_slot && in_ok && !valid_q[in_slot]) begin
      valid_d[in_slot] = 1'b1;
      await_d[in_slot] = 1'b0;
    end
    if (cmd_i.ack_chk && idx_ok_q && valid_q[idx_q] && (rd_id_q == ack_q)) begin
      await_d[idx_q] = 1'b0;
    end
    if (cmd_i.emit_to) begin
      await_d[scan_slot_i] = 1'b0;
    end
    if (cmd_i.emit_send) begin
      await_d[scan_slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      await_q      <= '0;
      timeout_q    <= TimeoutReset;
      id_ctr_q     <= '0;
      running_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      await_q <= await_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.set_run) begin
        running_q <= run_flag_i;
      end
      if (cmd_i.emit_send) begin
        id_ctr_q <= id_ctr_q + 32'd1;
      end
      if (cmd_i.emit_to || cmd_i.emit_send) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q    <= now_ms_i;
      ack_q    <= ack_id_i;
      idx_q    <= in_slot;
      idx_ok_q <= in_ok;
    end
    if (cmd_i.emit_to || cmd_i.emit_send) begin
      pend_q <= new_res;
    end
    if (push || cmd_i.flush) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_send) begin
      id_mem[scan_slot_i]   <= id_ctr_q;
      time_mem[scan_slot_i] <= now_q;
    end
    if (cmd_i.rd_in) begin
      rd_id_q   <= id_mem[in_slot];
      rd_time_q <= time_mem[in_slot];
    end else if (cmd_i.rd_scan) begin
      rd_id_q   <= id_mem[scan_slot_i];
      rd_time_q <= time_mem[scan_slot_i];
    end
  end

  assign sts_o.hit_to     = hit_to;
  assign sts_o.hit_send   = hit_send;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.running    = running_q;

  assign out_valid_o    = out_valid_q;
  assign report_kind_o  = out_q.kind;
  assign target_index_o = out_q.idx;
  assign beat_id_o      = out_q.id;
  assign stamp_ms_o     = out_q.stamp;
  assign last_o         = out_last_q;

endmodule

### rtl/hbs_ctrl.sv
// Controller of the heartbeat supervisor: transaction decode and the slot
// sequencer of a tick. Drives hbs_datapath through hbs_pkg command and status.
module hbs_ctrl #(
  parameter int unsigned MaxClients = hbs_pkg::MaxClientsDef,
  localparam int unsigned SlotW = (MaxClients > 1) ? $clog2(MaxClients) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  hbs_pkg::kind_e       kind_i,
  output logic                 in_stall_o,
  input  hbs_pkg::sts_t        sts_i,
  output hbs_pkg::cmd_t        cmd_o,
  output logic [SlotW-1:0]     scan_slot_o
);
  import hbs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACK    = 3'd1;
  localparam logic [2:0] S_TO_RD  = 3'd2;
  localparam logic [2:0] S_TO_CHK = 3'd3;
  localparam logic [2:0] S_SEND   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             last_slot;

  assign last_slot   = cnt_q == SlotW'(MaxClients - 1);
  assign scan_slot_o = cnt_q;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          unique case (kind_i)
            KIND_TICK: begin
              cnt_d   = '0;
              state_d = S_TO_RD;
            end
            KIND_REG:   cmd_o.reg_slot = 1'b1;
            KIND_ACK: begin
              cmd_o.rd_in = 1'b1;
              state_d     = S_ACK;
            end
            KIND_STATE: cmd_o.set_run = 1'b1;
            default: ;
          endcase
        end
      end
      S_ACK: begin
        cmd_o.ack_chk = 1'b1;
        state_d       = S_IDLE;
      end
      S_TO_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = S_TO_CHK;
      end
      S_TO_CHK: begin
        if (!(sts_i.hit_to && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.emit_to = sts_i.hit_to;
          if (last_slot) begin
            cnt_d   = '0;
            state_d = sts_i.running ? S_SEND : S_FLUSH;
          end else begin
            cnt_d   = cnt_q + SlotW'(1);
            state_d = S_TO_RD;
          end
        end
      end
      S_SEND: begin
        if (!(sts_i.hit_send && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.emit_send = sts_i.hit_send;
          if (last_slot) begin
            cnt_d   = '0;
            state_d = S_FLUSH;
          end else begin
            cnt_d = cnt_q + SlotW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/heartbeat_supervisor.sv
// Top level of the heartbeat supervisor: joins hbs_ctrl and hbs_datapath.
// Uses hbs_pkg.
//
// Registration and state-change transactions complete in the idle state; an
// acknowledgement also passes the ack-check state. A tick runs a timeout pass, then
// a send pass only while running, and a stalled output can hold it:
// the timeout pass spends a read state and a check state per slot on the
// single-port table of sent ids and times, the send pass one send state per slot,
// and a flush state releases the final result. Each result is held in a pending
// register so that the final result of a tick carries last; the block takes its
// next transaction as soon as that final result sits in the output register.
module heartbeat_supervisor #(
  parameter int unsigned MAX_CLIENTS = hbs_pkg::MaxClientsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hbs_pkg::kind_e       kind_i,
  input  logic [3:0]           client_index_i,
  input  logic [31:0]          ack_id_i,
  input  logic                 run_flag_i,
  input  logic [31:0]          now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 report_kind_o,
  output logic [3:0]           target_index_o,
  output logic [31:0]          beat_id_o,
  output logic [31:0]          stamp_ms_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);
  import hbs_pkg::*;

  localparam int unsigned SlotW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [SlotW-1:0] scan_slot;

  hbs_ctrl #(
    .MaxClients (MAX_CLIENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .scan_slot_o (scan_slot)
  );

  hbs_datapath #(
    .MaxClients (MAX_CLIENTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .scan_slot_i    (scan_slot),
    .client_index_i (client_index_i),
    .ack_id_i       (ack_id_i),
    .run_flag_i     (run_flag_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .report_kind_o  (report_kind_o),
    .target_index_o (target_index_o),
    .beat_id_o      (beat_id_o),
    .stamp_ms_o     (stamp_ms_o),
    .last_o         (last_o)
  );

endmodule

### rtl/hbs_checker.sv
// Port-level checker of the heartbeat supervisor, bound to the top level.
// Uses hbs_pkg and the macros of heartbeat_supervisor_assert.svh.
`include "heartbeat_supervisor_assert.svh"

module hbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        report_kind_o,
  input logic [3:0]  target_index_o,
  input logic [31:0] beat_id_o,
  input logic [31:0] stamp_ms_o,
  input logic        last_o
);
  import hbs_pkg::*;

  logic        out_acc;
  logic        prev_kind_q, prev_last_q;
  logic [31:0] prev_id_q;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_kind_q <= REPORT_SENT;
      prev_last_q <= 1'b1;
      prev_id_q   <= '0;
    end else if (out_acc) begin
      prev_kind_q <= report_kind_o;
      prev_last_q <= last_o;
      prev_id_q   <= beat_id_o;
    end
  end

  `HBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(beat_id_o) && $stable(stamp_ms_o) && $stable(target_index_o) && $stable(report_kind_o) && $stable(last_o))
  `HBS_ASSERT_IMPL(a_no_input_mid_tick, clk_i, rst_ni, in_valid_i && !in_stall_o, !(out_valid_o && !last_o))
  `HBS_ASSERT_IMPL(a_id_step, clk_i, rst_ni, out_acc && !prev_last_q && prev_kind_q == REPORT_SENT && report_kind_o == REPORT_SENT, beat_id_o == prev_id_q + 32'd1)
  `HBS_ASSERT_IMPL(a_lost_before_sent, clk_i, rst_ni, out_acc && !prev_last_q && prev_kind_q == REPORT_SENT, report_kind_o == REPORT_SENT)

endmodule

bind heartbeat_supervisor hbs_checker u_hbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .report_kind_o  (report_kind_o),
  .target_index_o (target_index_o),
  .beat_id_o      (beat_id_o),
  .stamp_ms_o     (stamp_ms_o),
  .last_o         (last_o)
);
